>>> rtl/core/rrp_pkg.sv
package rrp_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_RECT = 2'd1;
  localparam logic [1:0] STAT_OOB      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic [8:0] CFG_WIDTH_RST  = 9'd1;
  localparam logic [8:0] CFG_HEIGHT_RST = 9'd1;
  localparam logic [7:0] CFG_BG_RST     = 8'd32;

  localparam logic [7:0] KIND_FILLED  = 8'h52;
  localparam logic [7:0] KIND_OUTLINE = 8'h72;

  // signed width for box bounds and pixel positions in q13.8
  localparam int Q_W = 22;
  localparam logic signed [Q_W-1:0] Q_ONE = 22'sd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic prep;
    logic sweep;
    logic mem_read;
    logic cap_read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad_rect;
    logic       empty;
    logic       read_oob;
    logic       sweep_last;
  } sts_t;

endpackage

>>> rtl/core/rrp_if.sv
interface rrp_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         shape_kind;
  logic [7:0]         fill_char;
  logic signed [19:0] left_q;
  logic signed [19:0] top_q;
  logic signed [19:0] width_q;
  logic signed [19:0] height_q;
  logic [7:0]         read_col;
  logic [7:0]         read_row;

  modport source (output valid, operation, shape_kind, fill_char, left_q, top_q,
                  width_q, height_q, read_col, read_row, input ready);
  modport sink (input valid, operation, shape_kind, fill_char, left_q, top_q,
                width_q, height_q, read_col, read_row, output ready);
endinterface

interface rrp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] pixel_char;

  modport source (output valid, status, pixel_char, input ready);
  modport sink (input valid, status, pixel_char, output ready);
endinterface

interface rrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/rrp_ram.sv
module rrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rrp_ctrl.sv
module rrp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  output logic          result_valid,
  input  logic          result_ready,
  output rrp_pkg::cmd_t cmd,
  input  rrp_pkg::sts_t sts
);
  import rrp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.prep = 1'b1;
        case (sts.op)
          OP_CLEAR: state_next = sts.empty ? ST_FINISH : ST_SWEEP;
          OP_DRAW:  state_next = (sts.bad_rect || sts.empty) ? ST_FINISH : ST_SWEEP;
          OP_READ: begin
            if (sts.read_oob) begin
              state_next = ST_FINISH;
            end else begin
              cmd.mem_read = 1'b1;
              state_next   = ST_RD_WAIT;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_RD_WAIT: begin
        cmd.cap_read = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!result_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/rrp_datapath.sv
module rrp_datapath #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  rrp_pkg::cmd_t      cmd,
  output rrp_pkg::sts_t      sts,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic [1:0]         operation,
  input  logic [7:0]         shape_kind,
  input  logic [7:0]         fill_char,
  input  logic signed [19:0] left_q,
  input  logic signed [19:0] top_q,
  input  logic signed [19:0] width_q,
  input  logic signed [19:0] height_q,
  input  logic [7:0]         read_col,
  input  logic [7:0]         read_row,
  output logic [1:0]         status,
  output logic [7:0]         pixel_char
);
  import rrp_pkg::*;

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = DIM_W + 1;
  localparam int IDX_W = (DIM_W > 8) ? DIM_W : 8;
  localparam int AW    = 2 * DIM_W;
  localparam int DEPTH = 1 << AW;

  // configuration
  logic [8:0] canvas_width, canvas_height;
  logic [7:0] background_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= CFG_WIDTH_RST;
      canvas_height   <= CFG_HEIGHT_RST;
      background_char <= CFG_BG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  canvas_width    <= cfg_data;
        CFG_HEIGHT: canvas_height   <= cfg_data;
        CFG_BG:     background_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // register values above the canvas limit clamp to it
  logic [CNT_W-1:0] eff_w, eff_h;
  assign eff_w = (11'(canvas_width) > 11'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(canvas_width);
  assign eff_h = (11'(canvas_height) > 11'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                     : CNT_W'(canvas_height);

  // captured item
  logic [1:0]         op;
  logic [7:0]         kind, fill;
  logic signed [19:0] left_r, top_r, wid_r, hgt_r;
  logic [7:0]         col_r, row_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op     <= operation;
      kind   <= shape_kind;
      fill   <= fill_char;
      left_r <= left_q;
      top_r  <= top_q;
      wid_r  <= width_q;
      hgt_r  <= height_q;
      col_r  <= read_col;
      row_r  <= read_row;
    end
  end

  // box bounds, plus the inner box that an outline leaves untouched
  logic signed [Q_W-1:0] left_b, right_b, top_b, bot_b;
  logic signed [Q_W-1:0] left_in, right_in, top_in, bot_in;
  logic signed [Q_W-1:0] right_sum, bot_sum;

  assign right_sum = Q_W'(left_r) + Q_W'(wid_r);
  assign bot_sum   = Q_W'(top_r) + Q_W'(hgt_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      left_b   <= Q_W'(left_r);
      top_b    <= Q_W'(top_r);
      right_b  <= right_sum;
      bot_b    <= bot_sum;
      left_in  <= Q_W'(left_r) + Q_ONE;
      top_in   <= Q_W'(top_r) + Q_ONE;
      right_in <= right_sum - Q_ONE;
      bot_in   <= bot_sum - Q_ONE;
    end
  end

  logic is_outline, is_clear;
  assign is_outline = (kind == KIND_OUTLINE);
  assign is_clear   = (op == OP_CLEAR);

  assign sts.op       = op;
  assign sts.bad_rect = (wid_r <= 20'sd0) || (hgt_r <= 20'sd0) ||
                        ((kind != KIND_FILLED) && (kind != KIND_OUTLINE));
  assign sts.empty    = (eff_w == '0) || (eff_h == '0);
  assign sts.read_oob = (12'(col_r) >= 12'(eff_w)) || (12'(row_r) >= 12'(eff_h));

  // raster sweep counters
  logic [DIM_W-1:0] x, y;
  logic             x_last, y_last;

  assign x_last         = (CNT_W'(x) == eff_w - CNT_W'(1));
  assign y_last         = (CNT_W'(y) == eff_h - CNT_W'(1));
  assign sts.sweep_last = x_last && y_last;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x <= '0;
      y <= '0;
    end else if (cmd.sweep) begin
      if (x_last) begin
        x <= '0;
        y <= y + DIM_W'(1);
      end else begin
        x <= x + DIM_W'(1);
      end
    end
  end

  logic signed [Q_W-1:0] px, py;
  logic                  in_box, inner, paint;

  assign px     = $signed(Q_W'({x, 8'h00}));
  assign py     = $signed(Q_W'({y, 8'h00}));
  assign in_box = (px >= left_b) && (px <= right_b) && (py >= top_b) && (py <= bot_b);
  assign inner  = (px >= left_in) && (px <= right_in) && (py >= top_in) && (py <= bot_in);
  assign paint  = is_clear || (in_box && !(is_outline && inner));

  // canvas memory, row-major with a power-of-two row pitch
  logic [IDX_W-1:0] col_ext, row_ext;
  logic [7:0]       rdata, pix_res;

  assign col_ext = IDX_W'(col_r);
  assign row_ext = IDX_W'(row_r);

  rrp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (cmd.sweep && paint),
    .waddr ({y, x}),
    .wdata (is_clear ? background_char : fill),
    .re    (cmd.mem_read),
    .raddr ({row_ext[DIM_W-1:0], col_ext[DIM_W-1:0]}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_read) begin
      pix_res <= rdata;
    end
  end

  // result
  logic [1:0] status_next;
  logic [7:0] pixel_next;

  always_comb begin
    status_next = STAT_OK;
    pixel_next  = 8'd0;
    case (op)
      OP_DRAW: begin
        if (sts.bad_rect) begin
          status_next = STAT_BAD_RECT;
        end
      end
      OP_READ: begin
        if (sts.read_oob) begin
          status_next = STAT_OOB;
        end else begin
          pixel_next = pix_res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= status_next;
      pixel_char <= pixel_next;
    end
  end

endmodule

>>> rtl/core/rectangle_raster_painter_core.sv
// Character canvas painter. One item is in work at a time; the input is taken again
// once the previous item has moved into the output register, which holds the result
// until it is taken. A clear or draw item sweeps all W*H pixels, where W and H are the
// canvas width and height (clamped to MAX_DIM), through the single canvas write port,
// which visits one pixel per cycle in raster order; a rejected rectangle or an empty
// canvas skips the sweep. A read goes through the registered memory read. Configuration
// writes are taken every cycle. There is no clearing pass after reset: pixels are
// undefined until the first clear.
module rectangle_raster_painter_core #(
  parameter int MAX_DIM = 256
) (
  input logic          clk,
  input logic          rst,
  rrp_item_if.sink     item,
  rrp_result_if.source result,
  rrp_cfg_if.sink      cfg
);
  import rrp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  rrp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  rrp_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .operation  (item.operation),
    .shape_kind (item.shape_kind),
    .fill_char  (item.fill_char),
    .left_q     (item.left_q),
    .top_q      (item.top_q),
    .width_q    (item.width_q),
    .height_q   (item.height_q),
    .read_col   (item.read_col),
    .read_row   (item.read_row),
    .status     (result.status),
    .pixel_char (result.pixel_char)
  );

endmodule

>>> rtl/core/rrp_checker.sv
module rrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] status,
  input logic [7:0] pixel_char
);
  import rrp_pkg::*;

  // one item in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while another is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before it was taken");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == STAT_OK) || (status == STAT_BAD_RECT) ||
                     (status == STAT_OOB))
    else $error("undefined status code");

  a_pixel_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STAT_OK) |-> pixel_char == 8'd0)
    else $error("pixel returned with an error status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind rectangle_raster_painter_core rrp_checker u_rrp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .status       (result.status),
  .pixel_char   (result.pixel_char)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rrp_pkg::*;

  localparam int DIM = 256;
  localparam longint UNIT = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         kind;
    logic [7:0]         fill;
    logic signed [19:0] left;
    logic signed [19:0] top;
    logic signed [19:0] wid;
    logic signed [19:0] hgt;
    logic [7:0]         col;
    logic [7:0]         row;
  } rect_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel;
  } rect_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_FIXED
  } row_kind_e;

  typedef struct packed {
    row_kind_e    rk;
    rect_item_t   it;
    rect_result_t res;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrp_item_if   item_ch ();
  rrp_result_if res_ch ();
  rrp_cfg_if    cfg_ch ();

  rectangle_raster_painter_core #(
    .MAX_DIM(DIM)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the canvas and the registers
  logic [7:0] shadow_canvas [DIM][DIM];
  logic [8:0] shadow_w = CFG_WIDTH_RST;
  logic [8:0] shadow_h = CFG_HEIGHT_RST;
  logic [7:0] shadow_bg = CFG_BG_RST;

  rect_result_t pending_results [$];
  int n_sent = 0;
  int n_errors = 0;

  // config rows carry width in wid, height in hgt and background in fill
  step_t dir_steps [28] = '{
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd1, 8'd0}, '{STAT_OOB, 8'h00}},
    '{ROW_FIXED, '{OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd0, 8'd0}, '{STAT_OK, 8'd32}},
    '{ROW_FIXED, '{OP_DRAW, KIND_FILLED, 8'h41, 20'sd0, 20'sd0, 20'sd256, 20'sd256,
      '0, '0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd0, 8'd0}, '{STAT_OK, 8'h41}},
    '{ROW_FIXED, '{OP_DRAW, 8'h00, 8'hFF, 20'sh80000, 20'sh7FFFF, 20'sd256, 20'sd256,
      '0, '0}, '{STAT_BAD_RECT, 8'h00}},
    '{ROW_FIXED, '{OP_DRAW, KIND_FILLED, 8'h42, 20'sd0, 20'sd0, 20'sd0, 20'sd256,
      '0, '0}, '{STAT_BAD_RECT, 8'h00}},
    '{ROW_FIXED, '{OP_DRAW, KIND_OUTLINE, 8'h43, 20'sd0, 20'sd0, 20'sd256, 20'shFFFFF,
      '0, '0}, '{STAT_BAD_RECT, 8'h00}},
    '{ROW_FIXED, '{OP_DRAW, 8'hFF, 8'h44, 20'sd0, 20'sd0, 20'sh7FFFF, 20'sh7FFFF,
      '0, '0}, '{STAT_BAD_RECT, 8'h00}},
    '{ROW_FIXED, '{OP_DRAW, KIND_FILLED, 8'h45, 20'sd0, 20'sd0, 20'sh80000, 20'sd256,
      '0, '0}, '{STAT_BAD_RECT, 8'h00}},
    '{ROW_FIXED, '{OP_UNUSED, KIND_FILLED, 8'h46, 20'sd0, 20'sd0, 20'sd256, 20'sd256,
      8'd0, 8'd0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd255, 8'd255}, '{STAT_OOB, 8'h00}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd0, 8'd0}, '{STAT_OK, 8'h41}},
    '{ROW_CFG, '{OP_CLEAR, '0, 8'hFF, '0, '0, 20'sd8, 20'sd6, '0, '0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd7, 8'd5}, '{STAT_OK, 8'hFF}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd8, 8'd0}, '{STAT_OOB, 8'h00}},
    '{ROW_PRED, '{OP_DRAW, KIND_OUTLINE, 8'h23, 20'sd256, 20'sd256, 20'sd1280, 20'sd768,
      '0, '0}, '0},
    '{ROW_PRED, '{OP_DRAW, KIND_FILLED, 8'h2A, 20'sh80000, 20'sh80000, 20'sh7FFFF,
      20'sh7FFFF, '0, '0}, '0},
    '{ROW_PRED, '{OP_DRAW, KIND_FILLED, 8'h2B, 20'sh7FFFF, 20'sd0, 20'sh7FFFF, 20'sd256,
      '0, '0}, '0},
    '{ROW_PRED, '{OP_DRAW, KIND_OUTLINE, 8'h80, 20'sh00180, 20'shFFF80, 20'sh002C0,
      20'sh00280, '0, '0}, '0},
    '{ROW_PRED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd2, 8'd2}, '0},
    '{ROW_PRED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd1, 8'd1}, '0},
    '{ROW_PRED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd0, 8'd5}, '0},
    '{ROW_CFG, '{OP_CLEAR, '0, 8'h00, '0, '0, 20'sd0, 20'sd5, '0, '0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0}, '{STAT_OK, 8'h00}},
    '{ROW_FIXED, '{OP_READ, '0, '0, '0, '0, '0, '0, 8'd0, 8'd0}, '{STAT_OOB, 8'h00}},
    '{ROW_FIXED, '{OP_DRAW, KIND_FILLED, 8'h47, 20'sd0, 20'sd0, 20'sd256, 20'sd256,
      '0, '0}, '{STAT_OK, 8'h00}}
  };

  function automatic int send_idle_pct();
    return (n_sent < 45) ? 27 : (n_sent < 90) ? 80 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (n_sent < 45) ? 80 : (n_sent < 90) ? 27 : 0;
  endfunction

  // applies one item to the shadow canvas and returns the result it should give
  function automatic rect_result_t predict_result(rect_item_t it);
    rect_result_t r;
    int ew, eh, x, y;
    longint lft, tp, rgt, btm, px, py;
    bit inner;
    r = '{STAT_OK, 8'h00};
    ew = (shadow_w > 9'd256) ? DIM : int'(shadow_w);
    eh = (shadow_h > 9'd256) ? DIM : int'(shadow_h);
    case (it.op)
      OP_CLEAR: begin
        for (y = 0; y < eh; y++)
          for (x = 0; x < ew; x++)
            shadow_canvas[y][x] = shadow_bg;
      end
      OP_DRAW: begin
        if (it.wid <= 0 || it.hgt <= 0 ||
            (it.kind != KIND_FILLED && it.kind != KIND_OUTLINE)) begin
          r.status = STAT_BAD_RECT;
        end else begin
          lft = it.left;
          tp = it.top;
          rgt = lft + it.wid;
          btm = tp + it.hgt;
          for (y = 0; y < eh; y++) begin
            py = y * UNIT;
            for (x = 0; x < ew; x++) begin
              px = x * UNIT;
              if (px >= lft && px <= rgt && py >= tp && py <= btm) begin
                inner = px - UNIT >= lft && px + UNIT <= rgt &&
                        py - UNIT >= tp && py + UNIT <= btm;
                if (it.kind == KIND_FILLED || !inner)
                  shadow_canvas[y][x] = it.fill;
              end
            end
          end
        end
      end
      OP_READ: begin
        if (it.col >= ew || it.row >= eh)
          r.status = STAT_OOB;
        else
          r.pixel = shadow_canvas[it.row][it.col];
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly well-formed draws and in-canvas reads, the rest is noise
  function automatic rect_item_t random_item(int ew, int eh);
    rect_item_t it;
    int pick, span_x, span_y;
    it.op = 2'($urandom);
    it.kind = 8'($urandom);
    it.fill = 8'($urandom);
    it.left = 20'($urandom);
    it.top = 20'($urandom);
    it.wid = 20'($urandom);
    it.hgt = 20'($urandom);
    it.col = 8'($urandom);
    it.row = 8'($urandom);
    span_x = (ew + 4) * 256;
    span_y = (eh + 4) * 256;
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.op = OP_CLEAR;
    end else if (pick < 58) begin
      it.op = OP_DRAW;
      it.kind = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
      it.left = 20'($urandom_range(span_x) - 512);
      it.top = 20'($urandom_range(span_y) - 512);
      if ($urandom_range(3) == 0) begin
        it.wid = 20'($urandom_range(768, 1));
        it.hgt = 20'($urandom_range(768, 1));
      end else begin
        it.wid = 20'($urandom_range(span_x, 1));
        it.hgt = 20'($urandom_range(span_y, 1));
      end
      // a share of broken rectangles
      if (pick >= 48) begin
        case ($urandom_range(2))
          0: begin
            do it.kind = 8'($urandom);
            while (it.kind == KIND_FILLED || it.kind == KIND_OUTLINE);
          end
          1: it.wid = 20'(-$urandom_range(524288));
          default: it.hgt = 20'(-$urandom_range(524288));
        endcase
      end
    end else if (pick < 62) begin
      it.op = OP_DRAW;
      it.kind = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
    end else if (pick < 66) begin
      it.op = OP_UNUSED;
    end else begin
      it.op = OP_READ;
      if (ew > 0 && eh > 0 && $urandom_range(4) != 0) begin
        it.col = 8'($urandom_range(ew - 1));
        it.row = 8'($urandom_range(eh - 1));
      end
    end
    return it;
  endfunction

  task automatic send_item(input rect_item_t it, input bit fixed, input rect_result_t want);
    rect_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct()) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.operation <= it.op;
    item_ch.shape_kind <= it.kind;
    item_ch.fill_char <= it.fill;
    item_ch.left_q <= it.left;
    item_ch.top_q <= it.top;
    item_ch.width_q <= it.wid;
    item_ch.height_q <= it.hgt;
    item_ch.read_col <= it.col;
    item_ch.read_row <= it.row;
    do @(posedge clk); while (!item_ch.ready);
    r = predict_result(it);
    pending_results.push_back(fixed ? want : r);
    n_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [8:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_WIDTH: shadow_w = val;
      CFG_HEIGHT: shadow_h = val;
      CFG_BG: shadow_bg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [8:0] w, input logic [8:0] h, input logic [8:0] bg);
    wait_idle();
    cfg_put(CFG_WIDTH, w);
    cfg_put(CFG_HEIGHT, h);
    cfg_put(CFG_BG, bg);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
  end

  always @(posedge clk) begin
    rect_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, res_ch.status);
          n_errors++;
        end
        if (res_ch.pixel_char !== want.pixel) begin
          $error("pixel_char mismatch: expected 0x%02h, got 0x%02h",
                 want.pixel, res_ch.pixel_char);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rect_item_t it;
    int i, p, n, ew, eh;
    logic [8:0] w, h, bg;
    item_ch.valid = 1'b0;
    item_ch.operation = OP_CLEAR;
    item_ch.shape_kind = '0;
    item_ch.fill_char = '0;
    item_ch.left_q = '0;
    item_ch.top_q = '0;
    item_ch.width_q = '0;
    item_ch.height_q = '0;
    item_ch.read_col = '0;
    item_ch.read_row = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WIDTH;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(dir_steps); i++) begin
      case (dir_steps[i].rk)
        ROW_CFG: write_config(dir_steps[i].it.wid[8:0], dir_steps[i].it.hgt[8:0],
                              {1'b0, dir_steps[i].it.fill});
        ROW_FIXED: send_item(dir_steps[i].it, 1'b1, dir_steps[i].res);
        default: send_item(dir_steps[i].it, 1'b0, dir_steps[i].res);
      endcase
    end

    // each canvas setting starts with a clear so that every read hits a written pixel
    for (p = 0; p < 10; p++) begin
      w = 9'($urandom_range(20, 1));
      h = 9'($urandom_range(20, 1));
      bg = 9'($urandom);
      n = 11;
      case (p)
        0: bg = 9'h100;
        1: begin
          w = 9'd0;
          h = 9'($urandom_range(8, 1));
        end
        2: begin
          w = 9'd256;
          h = 9'd1;
          bg = 9'h0FF;
        end
        4: begin
          w = 9'd1;
          h = 9'd511;
        end
        6: begin
          w = 9'd511;
          h = 9'd256;
          n = 5;
        end
        7: begin
          w = 9'($urandom_range(6, 1));
          h = 9'd0;
        end
        8: begin
          w = 9'($urandom_range(40, 1));
          h = 9'($urandom_range(40, 1));
        end
        default: ;
      endcase
      write_config(w, h, bg);
      ew = (w > 9'd256) ? DIM : int'(w);
      eh = (h > 9'd256) ? DIM : int'(h);
      it = random_item(ew, eh);
      it.op = OP_CLEAR;
      send_item(it, 1'b0, '0);
      repeat (n - 1) send_item(random_item(ew, eh), 1'b0, '0);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rrp_pkg.sv
rtl/core/rrp_if.sv
rtl/core/rrp_ram.sv
rtl/core/rrp_ctrl.sv
rtl/core/rrp_datapath.sv
rtl/core/rectangle_raster_painter_core.sv
rtl/core/rrp_checker.sv
test/testbench.sv
